FILE: design/spq_pkg.sv
// ---------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Key layout, command and status codes, cell control and cell flags.
// ---------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned Depth   = 16;
  localparam int unsigned CntW    = $clog2(Depth + 1);
  localparam int unsigned CodeW   = 16;
  localparam int unsigned ValueW  = 24;
  localparam int unsigned WeightW = 24;
  localparam int unsigned KeyW    = WeightW + ValueW + CodeW;

  // weight is the most significant part, so a plain unsigned compare sorts
  typedef logic [KeyW-1:0] key_t;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_PEEK   = 2'd2;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_DUP   = 2'd1;
  localparam logic [1:0] STS_FULL  = 2'd2;
  localparam logic [1:0] STS_EMPTY = 2'd3;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP
  } spq_op_e;

  // what a cell reports about the incoming key
  typedef struct packed {
    logic goes;  // new key sorts at or before this cell, or cell is free
    logic dup;   // cell holds exactly the new key
  } cell_flags_t;

endpackage

FILE: design/spq_cell.sv
// ---------------------------------------------------------------------------
// spq_cell: one slot of the sorted shift-register queue
// Compares the incoming key with its own and takes its next key from the
// input, its left neighbor (insert shift) or its right neighbor (pop).
// ---------------------------------------------------------------------------
module spq_cell (
  input  logic                 clk_i,
  input  spq_pkg::spq_op_e     op_i,
  input  logic                 occupied_i,
  input  spq_pkg::key_t        new_key_i,
  input  spq_pkg::key_t        left_key_i,
  input  logic                 left_goes_i,
  input  spq_pkg::key_t        right_key_i,
  output spq_pkg::key_t        key_o,
  output spq_pkg::key_t        key_d_o,
  output spq_pkg::cell_flags_t flags_o
);
  import spq_pkg::*;

  key_t key_q;
  key_t key_d;

  assign flags_o.goes = !occupied_i || (new_key_i < key_q);
  assign flags_o.dup  = occupied_i && (new_key_i == key_q);

  always_comb begin
    key_d = key_q;
    case (op_i)
      OP_INSERT: begin
        if (flags_o.goes) begin
          key_d = left_goes_i ? left_key_i : new_key_i;
        end
      end
      OP_POP:  key_d = right_key_i;
      default: key_d = key_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o   = key_q;
  assign key_d_o = key_d;

endmodule

FILE: design/sorted_priority_queue_core.sv
// ---------------------------------------------------------------------------
// sorted_priority_queue_core: bounded sorted priority queue
// A row of compare-and-shift cells kept in ascending key order.
// ---------------------------------------------------------------------------
// Usage: the input channel (in_valid_i / in_ready_o) carries one command
// word: insert an entry, pop the head, or peek. The output channel
// (out_valid_o / out_ready_i) returns one word per command with the head
// entry, the occupancy and a status (ok, duplicate, full, pop on empty).
// Every cell compares the new key with its own in parallel and shifts in
// the same cycle; the result word is held in the single output register
// and is valid the cycle after acceptance, and a new command is accepted
// every cycle while the receiver keeps up. While the receiver stalls,
// in_ready_o drops until the waiting word is taken, and nothing is lost.
// Reset empties the queue and clears the output flags, occupancy and status,
// not the head key or cells; only the occupancy decides which cells count.
// ---------------------------------------------------------------------------
module sorted_priority_queue_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  command_i,
  input  logic [spq_pkg::CodeW-1:0]   entry_code_i,
  input  logic [spq_pkg::ValueW-1:0]  entry_value_i,
  input  logic [spq_pkg::WeightW-1:0] entry_weight_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        head_valid_o,
  output logic [spq_pkg::CodeW-1:0]   head_code_o,
  output logic [spq_pkg::ValueW-1:0]  head_value_o,
  output logic [spq_pkg::WeightW-1:0] head_weight_o,
  output logic [spq_pkg::CntW-1:0]    occupancy_o,
  output logic [1:0]                  status_o
);
  import spq_pkg::*;

  key_t        new_key;
  key_t        cell_key   [Depth];
  key_t        cell_key_d [Depth];
  cell_flags_t cell_flags [Depth];
  logic [Depth-1:0] dup_vec;
  logic        any_dup;
  logic        full;
  logic        fire;
  spq_op_e     op;
  logic [1:0]  status_d;
  logic [CntW-1:0] count_q, count_d;

  logic                 out_valid_q;
  logic                 head_valid_q;
  key_t                 head_key_q;
  logic [CntW-1:0]      occupancy_q;
  logic [1:0]           status_q;

  assign new_key    = {entry_weight_i, entry_value_i, entry_code_i};
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;
  assign full       = (count_q == CntW'(Depth));

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic occupied;
    key_t left_key;
    logic left_goes;
    key_t right_key;

    assign occupied   = (count_q > CntW'(i));
    assign dup_vec[i] = cell_flags[i].dup;

    if (i == 0) begin : g_first
      assign left_key  = '0;
      assign left_goes = 1'b0;
    end else begin : g_mid
      assign left_key  = cell_key[i-1];
      assign left_goes = cell_flags[i-1].goes;
    end

    if (i == Depth - 1) begin : g_last
      assign right_key = cell_key[i];
    end else begin : g_inner
      assign right_key = cell_key[i+1];
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .op_i        (op),
      .occupied_i  (occupied),
      .new_key_i   (new_key),
      .left_key_i  (left_key),
      .left_goes_i (left_goes),
      .right_key_i (right_key),
      .key_o       (cell_key[i]),
      .key_d_o     (cell_key_d[i]),
      .flags_o     (cell_flags[i])
    );
  end

  assign any_dup = |dup_vec;

  always_comb begin
    op       = OP_HOLD;
    status_d = STS_OK;
    count_d  = count_q;
    case (command_i)
      CMD_INSERT: begin
        if (any_dup) begin
          status_d = STS_DUP;
        end else if (full) begin
          status_d = STS_FULL;
        end else begin
          op      = fire ? OP_INSERT : OP_HOLD;
          count_d = count_q + CntW'(1);
        end
      end
      CMD_POP: begin
        if (count_q == '0) begin
          status_d = STS_EMPTY;
        end else begin
          op      = fire ? OP_POP : OP_HOLD;
          count_d = count_q - CntW'(1);
        end
      end
      default: begin
        op = OP_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      head_valid_q <= 1'b0;
      occupancy_q  <= '0;
      status_q     <= STS_OK;
    end else begin
      if (fire) begin
        count_q      <= count_d;
        out_valid_q  <= 1'b1;
        head_valid_q <= (count_d != '0);
        occupancy_q  <= count_d;
        status_q     <= status_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // head word is payload only
  always_ff @(posedge clk_i) begin
    if (fire) begin
      head_key_q <= (count_d != '0) ? cell_key_d[0] : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign head_valid_o  = head_valid_q;
  assign head_code_o   = head_key_q[CodeW-1:0];
  assign head_value_o  = head_key_q[CodeW +: ValueW];
  assign head_weight_o = head_key_q[CodeW+ValueW +: WeightW];
  assign occupancy_o   = occupancy_q;
  assign status_o      = status_q;

`ifndef ASSERT_OFF
  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && command_i == CMD_POP && count_q != '0 |=> count_q == $past(count_q) - CntW'(1))
    else $error("pop did not decrement occupancy");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q == STS_FULL |-> occupancy_q == CntW'(Depth))
    else $error("full status reported below capacity");

  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> head_valid_q == (occupancy_q != '0))
    else $error("head valid disagrees with occupancy");

  a_sorted_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= CntW'(2) |-> cell_key[0] < cell_key[1])
    else $error("head cells out of order");
`endif

endmodule

FILE: verif/sorted_priority_queue_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_priority_queue_core_tb: self-checking testbench of the priority queue
// Sends insert, pop, peek and unused command words, keeps a sorted model of
// the queue and checks every returned head word field by field, in phases
// with no idling, sender gaps, receiver stalls and both at once.
// ---------------------------------------------------------------------------
module sorted_priority_queue_core_tb;
  import spq_pkg::*;

  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned PrintLimit  = 40;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [CodeW-1:0]   code;
    logic [ValueW-1:0]  value;
    logic [WeightW-1:0] weight;
  } cmd_word_t;

  typedef struct packed {
    logic               head_valid;
    logic [CodeW-1:0]   code;
    logic [ValueW-1:0]  value;
    logic [WeightW-1:0] weight;
    logic [CntW-1:0]    occupancy;
    logic [1:0]         status;
  } head_word_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_ready_o;
  logic [1:0]          command_i      = CMD_PEEK;
  logic [CodeW-1:0]    entry_code_i   = '0;
  logic [ValueW-1:0]   entry_value_i  = '0;
  logic [WeightW-1:0]  entry_weight_i = '0;
  logic                out_valid_o;
  logic                out_ready_i    = 1'b0;
  logic                head_valid_o;
  logic [CodeW-1:0]    head_code_o;
  logic [ValueW-1:0]   head_value_o;
  logic [WeightW-1:0]  head_weight_o;
  logic [CntW-1:0]     occupancy_o;
  logic [1:0]          status_o;

  // sorted model of the queue contents
  key_t        model_keys [Depth];
  int          model_count = 0;

  cmd_word_t   words_pending [$];
  head_word_t  heads_due [$];
  cmd_word_t   drive_word;
  head_word_t  due_word;
  key_t        key_pool [8];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count    = 0;
  int unsigned mismatches     = 0;
  int unsigned words_checked  = 0;
  int unsigned n_inserts = 0, n_pops = 0, n_peeks = 0;
  int unsigned n_dups = 0, n_full = 0, n_empty_pops = 0, peak_count = 0;

  sorted_priority_queue_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .entry_code_i   (entry_code_i),
    .entry_value_i  (entry_value_i),
    .entry_weight_i (entry_weight_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .head_valid_o   (head_valid_o),
    .head_code_o    (head_code_o),
    .head_value_o   (head_value_o),
    .head_weight_o  (head_weight_o),
    .occupancy_o    (occupancy_o),
    .status_o       (status_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d words still due", cycle_count, heads_due.size());
      $display("sorted_priority_queue_core test failed");
      $finish;
    end
  end

  // applies one command to the model and returns the head word it should give
  function automatic head_word_t apply_command(cmd_word_t w);
    key_t       key;
    logic       dup;
    int         pos;
    head_word_t r;
    key = {w.weight, w.value, w.code};
    r = '0;
    r.status = STS_OK;
    case (w.cmd)
      CMD_INSERT: begin
        n_inserts++;
        dup = 1'b0;
        for (int i = 0; i < model_count; i++) begin
          if (model_keys[i] == key) dup = 1'b1;
        end
        if (dup) begin
          r.status = STS_DUP;
          n_dups++;
        end else if (model_count == Depth) begin
          r.status = STS_FULL;
          n_full++;
        end else begin
          // shift larger keys up one cell, an equal weight sorts by value then code
          pos = model_count;
          while (pos > 0 && key < model_keys[pos-1]) begin
            model_keys[pos] = model_keys[pos-1];
            pos--;
          end
          model_keys[pos] = key;
          model_count++;
        end
      end
      CMD_POP: begin
        n_pops++;
        if (model_count == 0) begin
          r.status = STS_EMPTY;
          n_empty_pops++;
        end else begin
          for (int i = 1; i < model_count; i++) model_keys[i-1] = model_keys[i];
          model_count--;
        end
      end
      default: n_peeks++;
    endcase
    if (model_count > 0) begin
      r.head_valid = 1'b1;
      {r.weight, r.value, r.code} = model_keys[0];
    end
    r.occupancy = CntW'(model_count);
    if (model_count > peak_count) peak_count = model_count;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    if (mismatches < PrintLimit)
      $display("mismatch at word %0d: %s got 0x%0h expected 0x%0h",
               words_checked, what, got, want);
    mismatches++;
  endtask

  // driver: valid holds until taken, then the next word or a gap
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o)
        heads_due.push_back(apply_command({command_i, entry_code_i, entry_value_i,
                                           entry_weight_i}));
      if (!in_valid_i || in_ready_o) begin
        if (words_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drive_word = words_pending.pop_front();
          in_valid_i     <= 1'b1;
          command_i      <= drive_word.cmd;
          entry_code_i   <= drive_word.code;
          entry_value_i  <= drive_word.value;
          entry_weight_i <= drive_word.weight;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: compares every taken word with the oldest one due
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (heads_due.size() == 0) begin
          report_mismatch("word with none due, status", status_o, 0);
        end else begin
          due_word = heads_due.pop_front();
          if (head_valid_o !== due_word.head_valid)
            report_mismatch("head_valid", head_valid_o, due_word.head_valid);
          if (head_code_o !== due_word.code)
            report_mismatch("head_code", head_code_o, due_word.code);
          if (head_value_o !== due_word.value)
            report_mismatch("head_value", head_value_o, due_word.value);
          if (head_weight_o !== due_word.weight)
            report_mismatch("head_weight", head_weight_o, due_word.weight);
          if (occupancy_o !== due_word.occupancy)
            report_mismatch("occupancy", occupancy_o, due_word.occupancy);
          if (status_o !== due_word.status)
            report_mismatch("status", status_o, due_word.status);
        end
        words_checked++;
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void push_word(logic [1:0] cmd, logic [CodeW-1:0] code,
                                    logic [ValueW-1:0] value, logic [WeightW-1:0] weight);
    words_pending.push_back({cmd, code, value, weight});
  endfunction

  // mix of repeated keys, weight ties, field extremes and full-range keys
  function automatic key_t random_key();
    int unsigned pick;
    key_t        k;
    pick = $urandom_range(99);
    k = {$urandom(), $urandom()};
    if (pick < 30) begin
      k = key_pool[$urandom_range(7)];
    end else if (pick < 50) begin
      k[KeyW-1 -: WeightW] = key_pool[$urandom_range(7)][KeyW-1 -: WeightW];
      if ($urandom_range(1)) k[CodeW +: ValueW] = key_pool[$urandom_range(7)][CodeW +: ValueW];
    end else if (pick < 60) begin
      k[KeyW-1 -: WeightW] = $urandom_range(1) ? '1 : '0;
      k[CodeW +: ValueW]   = $urandom_range(1) ? '1 : '0;
      k[CodeW-1:0]         = $urandom_range(1) ? '1 : '0;
    end
    return k;
  endfunction

  function automatic void push_random(int unsigned insert_pct);
    int unsigned pick;
    key_t        k;
    logic [1:0]  cmd;
    pick = $urandom_range(99);
    k = random_key();
    if (pick < insert_pct) cmd = CMD_INSERT;
    else begin
      pick = $urandom_range(99);
      cmd = (pick < 75) ? CMD_POP : (pick < 90) ? CMD_PEEK : CMD_UNUSED;
    end
    push_word(cmd, k[CodeW-1:0], k[CodeW +: ValueW], k[KeyW-1 -: WeightW]);
  endfunction

  task automatic wait_drained();
    while (words_pending.size() != 0 || in_valid_i || heads_due.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    int unsigned insert_pct;
    for (int i = 0; i < 8; i++) key_pool[i] = {$urandom(), $urandom()};
    key_pool[0][KeyW-1 -: WeightW] = '1;
    key_pool[1] = '0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty queue corners, then fill to the brim and overflow
    push_word(CMD_PEEK, '1, '1, '1);
    push_word(CMD_POP, '0, '0, '0);
    push_word(CMD_UNUSED, '1, '0, '1);
    push_word(CMD_INSERT, '1, '1, '1);
    push_word(CMD_INSERT, '0, '0, '0);
    push_word(CMD_INSERT, '1, '1, '1);
    push_word(CMD_INSERT, 16'd1, '0, '0);
    push_word(CMD_INSERT, '0, 24'd1, '0);
    push_word(CMD_INSERT, '0, '0, 24'd1);
    push_word(CMD_INSERT, 16'hfffe, '1, '1);
    for (int i = 0; i < 10; i++)
      push_word(CMD_INSERT, CodeW'(i), ValueW'(24'h5a5a5a ^ i), 24'h800000 >> i);
    push_word(CMD_INSERT, 16'h1234, 24'h123456, 24'h000100);
    push_word(CMD_INSERT, '0, '0, '0);
    push_word(CMD_POP, '0, '0, '0);
    push_word(CMD_PEEK, '0, '0, '0);
    push_word(CMD_POP, '0, '0, '0);
    wait_drained();

    // phases rotate the idling pattern; segments swing between fill and drain
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        case ((phase + seg) % 3)
          0: insert_pct = 80;
          1: insert_pct = 50;
          default: insert_pct = 20;
        endcase
        for (int i = 0; i < 23; i++) push_random(insert_pct);
      end
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    $display("checked %0d words: %0d inserts, %0d pops, %0d peeks, peak occupancy %0d",
             words_checked, n_inserts, n_pops, n_peeks, peak_count);
    $display("duplicates %0d, dropped when full %0d, pops on empty %0d, mismatches %0d",
             n_dups, n_full, n_empty_pops, mismatches);
    if (mismatches == 0 && heads_due.size() == 0) begin
      $display("sorted_priority_queue_core test passed");
    end else begin
      $display("sorted_priority_queue_core test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue_core.sv
verif/sorted_priority_queue_core_tb.sv
